FILE: hdl/thermal_grid_centroid_core_assert.svh
// assertion macros for the thermal grid centroid controller
`ifndef THERMAL_GRID_CENTROID_CORE_ASSERT_SVH
`define THERMAL_GRID_CENTROID_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tgc_pkg.sv
// shared types, constants and control structs of the thermal grid centroid block
package tgc_pkg;

  localparam int TEMP_W          = 12;
  localparam int MINW_W          = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CENT_W          = 11;
  localparam int FRAC_W          = 8;
  localparam int GRID_COLS_DEF   = 8;
  localparam int GRID_PIXELS_DEF = 64;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [MINW_W-1:0]        min_weight_t;
  typedef logic [CENT_W-1:0]        cent_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

  localparam temp_t       THRESH_RST     = 12'sd104;
  localparam min_weight_t MIN_WEIGHT_RST = 16'd4;
  localparam cent_t       CENT_SAT       = '1;

  localparam cfg_idx_t REG_HEAT_THRESHOLD = 1'd0;
  localparam cfg_idx_t REG_MIN_WEIGHT     = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic acc_en;
    logic div_init;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic pix_last;
    logic frame_end;
    logic div_last;
  } dp_status_t;

endpackage

FILE: hdl/tgc_if.sv
// pixel, result and register write channel interfaces
interface tgc_in_if;
  import tgc_pkg::*;
  logic  valid;
  logic  ready;
  temp_t pixel_temp;
  logic  frame_start;
  modport source (output valid, output pixel_temp, output frame_start, input ready);
  modport sink   (input valid, input pixel_temp, input frame_start, output ready);
endinterface

interface tgc_out_if;
  import tgc_pkg::*;
  logic  valid;
  logic  ready;
  cent_t cent_x;
  cent_t cent_y;
  logic  hot_found;
  modport source (output valid, output cent_x, output cent_y,
                  output hot_found, input ready);
  modport sink   (input valid, input cent_x, input cent_y,
                  input hot_found, output ready);
endinterface

interface tgc_cfg_if;
  import tgc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  addr;
  cfg_data_t data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: hdl/tgc_datapath.sv
// accumulators, pixel counters, register file and dual restoring divider
module tgc_datapath #(
  parameter int GRID_COLS   = tgc_pkg::GRID_COLS_DEF,
  parameter int GRID_PIXELS = tgc_pkg::GRID_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tgc_pkg::dp_cmd_t   cmd,
  output tgc_pkg::dp_status_t status,
  input  tgc_pkg::temp_t     pixel_temp,
  input  logic               frame_start,
  input  logic               cfg_we,
  input  tgc_pkg::cfg_idx_t  cfg_addr,
  input  tgc_pkg::cfg_data_t cfg_data,
  output tgc_pkg::cent_t     cent_x,
  output tgc_pkg::cent_t     cent_y,
  output logic               hot_found
);
  import tgc_pkg::*;

  localparam int PIX_W   = $clog2(GRID_PIXELS);
  localparam int COL_W   = $clog2(GRID_COLS);
  localparam int ROWS    = (GRID_PIXELS + GRID_COLS - 1) / GRID_COLS;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EXC_W   = TEMP_W;
  localparam int WSUM_W  = EXC_W + PIX_W;
  localparam int CSUM_W  = EXC_W + COL_W + PIX_W;
  localparam int RSUM_W  = EXC_W + ROW_W + PIX_W;
  localparam int SHIFT_W = CENT_W - FRAC_W;
  localparam int CMP_A   = (CSUM_W > RSUM_W) ? CSUM_W : RSUM_W;
  localparam int CMP_W   = (CMP_A > WSUM_W + SHIFT_W) ? CMP_A : WSUM_W + SHIFT_W;
  localparam int DET_W   = (WSUM_W > MINW_W) ? WSUM_W : MINW_W;
  localparam int REM_W   = WSUM_W + 1;
  localparam int IT_W    = $clog2(CENT_W);

  // configuration registers
  temp_t       thresh_r;
  min_weight_t min_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      min_w_r  <= MIN_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEAT_THRESHOLD: thresh_r <= temp_t'(cfg_data[TEMP_W-1:0]);
        REG_MIN_WEIGHT:     min_w_r  <= cfg_data[MINW_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulation
  logic [PIX_W-1:0]  pix_r, pix_b;
  logic [COL_W-1:0]  col_r, col_b;
  logic [ROW_W-1:0]  row_r, row_b;
  logic [WSUM_W-1:0] wsum_r, wsum_b, wsum_nxt;
  logic [CSUM_W-1:0] csum_r, csum_b, csum_nxt;
  logic [RSUM_W-1:0] rsum_r, rsum_b, rsum_nxt;
  logic signed [TEMP_W:0]  diff;
  logic                    hot;
  logic [EXC_W-1:0]        excess;
  logic [COL_W+EXC_W-1:0]  prod_c;
  logic [ROW_W+EXC_W-1:0]  prod_r;
  logic                    last_b;

  always_comb begin
    pix_b    = frame_start ? '0 : pix_r;
    col_b    = frame_start ? '0 : col_r;
    row_b    = frame_start ? '0 : row_r;
    wsum_b   = frame_start ? '0 : wsum_r;
    csum_b   = frame_start ? '0 : csum_r;
    rsum_b   = frame_start ? '0 : rsum_r;
    diff     = {pixel_temp[TEMP_W-1], pixel_temp} - {thresh_r[TEMP_W-1], thresh_r};
    hot      = !diff[TEMP_W] && (diff != '0);
    excess   = hot ? diff[EXC_W-1:0] : '0;
    prod_c   = col_b * excess;
    prod_r   = row_b * excess;
    wsum_nxt = wsum_b + WSUM_W'(excess);
    csum_nxt = csum_b + CSUM_W'(prod_c);
    rsum_nxt = rsum_b + RSUM_W'(prod_r);
    last_b   = (pix_b == PIX_W'(GRID_PIXELS - 1));
  end

  assign status.pix_last  = (pix_r == PIX_W'(GRID_PIXELS - 1));
  assign status.frame_end = cmd.acc_en && last_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      wsum_r <= '0;
      csum_r <= '0;
      rsum_r <= '0;
    end else if (cmd.acc_en) begin
      if (last_b) begin
        pix_r  <= '0;
        col_r  <= '0;
        row_r  <= '0;
        wsum_r <= '0;
        csum_r <= '0;
        rsum_r <= '0;
      end else begin
        pix_r  <= pix_b + PIX_W'(1);
        wsum_r <= wsum_nxt;
        csum_r <= csum_nxt;
        rsum_r <= rsum_nxt;
        if (col_b == COL_W'(GRID_COLS - 1)) begin
          col_r <= '0;
          row_r <= row_b + ROW_W'(1);
        end else begin
          col_r <= col_b + COL_W'(1);
          row_r <= row_b;
        end
      end
    end
  end

  // frame snapshot and divider
  logic [WSUM_W-1:0] snap_w_r;
  logic [CSUM_W-1:0] snap_x_r;
  logic [RSUM_W-1:0] snap_y_r;
  logic [WSUM_W-1:0] rem_x_r, rem_y_r;
  cent_t             low_x_r, low_y_r, q_x_r, q_y_r;
  logic              sat_x_r, sat_y_r, det_r;
  logic [IT_W-1:0]   it_r;
  logic [REM_W-1:0]  trial_x, trial_y;
  logic              ge_x, ge_y;
  cent_t             cx_r, cy_r;
  logic              hd_r;

  always_comb begin
    trial_x = {rem_x_r, low_x_r[CENT_W-1]};
    trial_y = {rem_y_r, low_y_r[CENT_W-1]};
    ge_x    = (trial_x >= {1'b0, snap_w_r});
    ge_y    = (trial_y >= {1'b0, snap_w_r});
  end

  assign status.div_last = (it_r == IT_W'(CENT_W - 1));

  always_ff @(posedge clk) begin
    if (status.frame_end) begin
      snap_w_r <= wsum_nxt;
      snap_x_r <= csum_nxt;
      snap_y_r <= rsum_nxt;
    end
    if (cmd.div_init) begin
      det_r   <= (DET_W'(snap_w_r) > DET_W'(min_w_r));
      sat_x_r <= (CMP_W'(snap_x_r) >= (CMP_W'(snap_w_r) << SHIFT_W));
      sat_y_r <= (CMP_W'(snap_y_r) >= (CMP_W'(snap_w_r) << SHIFT_W));
      rem_x_r <= WSUM_W'(snap_x_r >> SHIFT_W);
      rem_y_r <= WSUM_W'(snap_y_r >> SHIFT_W);
      low_x_r <= CENT_W'({snap_x_r, {FRAC_W{1'b0}}});
      low_y_r <= CENT_W'({snap_y_r, {FRAC_W{1'b0}}});
      q_x_r   <= '0;
      q_y_r   <= '0;
      it_r    <= '0;
    end else if (cmd.div_step) begin
      rem_x_r <= ge_x ? WSUM_W'(trial_x - {1'b0, snap_w_r}) : WSUM_W'(trial_x);
      rem_y_r <= ge_y ? WSUM_W'(trial_y - {1'b0, snap_w_r}) : WSUM_W'(trial_y);
      low_x_r <= {low_x_r[CENT_W-2:0], 1'b0};
      low_y_r <= {low_y_r[CENT_W-2:0], 1'b0};
      q_x_r   <= {q_x_r[CENT_W-2:0], ge_x};
      q_y_r   <= {q_y_r[CENT_W-2:0], ge_y};
      it_r    <= it_r + IT_W'(1);
    end
    if (cmd.emit) begin
      cx_r <= det_r ? (sat_x_r ? CENT_SAT : q_x_r) : '0;
      cy_r <= det_r ? (sat_y_r ? CENT_SAT : q_y_r) : '0;
      hd_r <= det_r;
    end
  end

  assign cent_x    = cx_r;
  assign cent_y    = cy_r;
  assign hot_found = hd_r;

endmodule

FILE: hdl/tgc_ctrl.sv
// frame controller: input stall, divider sequencing and result beat
module tgc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tgc_pkg::dp_cmd_t    cmd,
  input  tgc_pkg::dp_status_t status
);
  import tgc_pkg::*;
  `include "thermal_grid_centroid_core_assert.svh"

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (status.frame_end) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_DIV;
      ST_DIV:   if (status.div_last) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_r != ST_IDLE);
    in_ready     = !(status.pix_last && busy);
    cmd.acc_en   = in_valid && in_ready;
    cmd.div_init = 1'b0;
    cmd.div_step = 1'b0;
    cmd.emit     = 1'b0;
    unique case (state_r)
      ST_IDLE:  ;
      ST_CHECK: cmd.div_init = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_DONE:  cmd.emit = !out_valid_r || out_ready;
      default:  ;
    endcase
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `TGC_ASSERT_NOW(a_frame_end_idle, status.frame_end, state_r == ST_IDLE, "frame ended while divider busy")
  `TGC_ASSERT_NEXT(a_check_to_div, state_r == ST_CHECK, state_r == ST_DIV, "divider init not followed by steps")
  `TGC_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r && (state_r == ST_IDLE), "result beat not presented")
  `TGC_ASSERT_NOW(a_no_stall_early, !status.pix_last, in_ready, "pixel stalled before last pixel of frame")

endmodule

FILE: hdl/thermal_grid_centroid_core.sv
// Thermal grid centroid: takes one pixel beat per cycle in row-major order, save for the stall
// of a frame's last pixel described below, thresholds it and accumulates weight, column and row
// sums; after pixel GRID_PIXELS-1 it emits one result beat with the 8-fraction-bit centroid
// (saturated to 2047) and the detected flag, or all zeros. The centroid is computed after the
// frame by a restoring divider that resolves one quotient bit per cycle for both axes at once,
// so the result beat follows the last pixel after a compare, 11 steps and an emit, while the
// next frame is already accumulating. The last pixel of a frame is stalled only while the
// previous frame's divider or its untaken result still holds the divider. Register writes
// are always ready and should be issued with the block idle.
module thermal_grid_centroid_core #(
  parameter int GRID_COLS   = tgc_pkg::GRID_COLS_DEF,
  parameter int GRID_PIXELS = tgc_pkg::GRID_PIXELS_DEF
) (
  input logic   clk,
  input logic   rst_n,
  tgc_in_if.sink     in_ch,
  tgc_out_if.source  out_ch,
  tgc_cfg_if.sink    cfg_ch
);
  import tgc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  tgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  tgc_datapath #(
    .GRID_COLS   (GRID_COLS),
    .GRID_PIXELS (GRID_PIXELS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .pixel_temp  (in_ch.pixel_temp),
    .frame_start (in_ch.frame_start),
    .cfg_we      (cfg_ch.valid),
    .cfg_addr    (cfg_ch.addr),
    .cfg_data    (cfg_ch.data),
    .cent_x      (out_ch.cent_x),
    .cent_y      (out_ch.cent_y),
    .hot_found   (out_ch.hot_found)
  );

endmodule

FILE: test/tb_thermal_grid_centroid_core.sv
// testbench for thermal_grid_centroid_core: directed and random frames checked against a predictor
`timescale 1ns / 100ps

module tb_thermal_grid_centroid_core;
  import tgc_pkg::*;

  localparam int NCOLS = GRID_COLS_DEF;
  localparam int NPIX = GRID_PIXELS_DEF;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    cent_t x;
    cent_t y;
    logic  det;
  } centroid_beat_t;

  typedef enum {
    FR_SCATTER,
    FR_BLOB,
    FR_COLD,
    FR_SATURATED,
    FR_EDGE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  tgc_in_if  in_ch();
  tgc_out_if out_ch();
  tgc_cfg_if cfg_ch();

  thermal_grid_centroid_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  temp_t       thresh_q = THRESH_RST;
  min_weight_t minw_q = MIN_WEIGHT_RST;
  int          pix_idx = 0;
  longint      weight_acc = 0;
  longint      col_acc = 0;
  longint      row_acc = 0;

  centroid_beat_t pending_centroids[$];
  int mismatch_cnt = 0;
  bit idle_en = 1'b1;
  int hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic temp_t clamp_temp(int v);
    if (v > 2047) return temp_t'(2047);
    if (v < -2048) return temp_t'(-2048);
    return temp_t'(v);
  endfunction

  function automatic cent_t fixed_quotient(longint num, longint den);
    longint q;
    q = (num << FRAC_W) / den;
    return (q > 2047) ? CENT_SAT : cent_t'(q);
  endfunction

  function automatic temp_t frame_pixel(frame_kind_t kind, int idx, int cx, int cy, int rad);
    int col, row, span, base, v;
    col = idx % NCOLS;
    row = idx / NCOLS;
    span = (col > cx ? col - cx : cx - col) + (row > cy ? row - cy : cy - row);
    base = int'(thresh_q);
    case (kind)
      FR_SCATTER: v = int'($urandom_range(0, 4095)) - 2048;
      FR_BLOB: v = (span <= rad) ? base + int'($urandom_range(1, 800))
                                 : base - int'($urandom_range(0, 300));
      FR_COLD: v = base - int'($urandom_range(0, 4095));
      FR_SATURATED: v = 2047 - int'($urandom_range(0, 3));
      default: v = base + int'($urandom_range(0, 2)) - 1;
    endcase
    return clamp_temp(v);
  endfunction

  task automatic clear_sums();
    pix_idx = 0;
    weight_acc = 0;
    col_acc = 0;
    row_acc = 0;
  endtask

  task automatic track_pixel(temp_t t, logic fs);
    int excess;
    centroid_beat_t beat;
    if (fs) clear_sums();
    if (t > thresh_q) begin
      excess = int'(t) - int'(thresh_q);
      weight_acc += excess;
      col_acc += longint'(pix_idx % NCOLS) * excess;
      row_acc += longint'(pix_idx / NCOLS) * excess;
    end
    pix_idx++;
    if (pix_idx == NPIX) begin
      if (weight_acc > longint'(minw_q)) begin
        beat.x = fixed_quotient(col_acc, weight_acc);
        beat.y = fixed_quotient(row_acc, weight_acc);
        beat.det = 1'b1;
      end else begin
        beat.x = '0;
        beat.y = '0;
        beat.det = 1'b0;
      end
      pending_centroids.push_back(beat);
      clear_sums();
    end
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_pixel(temp_t t, logic fs);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_temp <= t;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_pixel(t, fs);
    @(negedge clk);
  endtask

  task automatic send_frame(temp_t bg, int n_hot, temp_t hot_val, int spot, temp_t spot_val,
                            logic fs);
    temp_t v;
    for (int i = 0; i < NPIX; i++) begin
      v = (i == spot) ? spot_val : (i < n_hot) ? hot_val : bg;
      send_pixel(v, fs && i == 0);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_centroids.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_HEAT_THRESHOLD: thresh_q = temp_t'(val[TEMP_W-1:0]);
      REG_MIN_WEIGHT: minw_q = min_weight_t'(val);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(temp_t thr, min_weight_t minw);
    wait_idle();
    write_reg(REG_HEAT_THRESHOLD, cfg_data_t'(int'(thr)));
    write_reg(REG_MIN_WEIGHT, cfg_data_t'(minw));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_frames(int n_frames, bit allow_idle);
    frame_kind_t kind;
    int cx, cy, rad, n;
    bit use_fs, broken, need_fs;
    need_fs = 1'b0;
    for (int f = 0; f < n_frames; f++) begin
      kind = frame_kind_t'($urandom_range(0, 4));
      cx = $urandom_range(0, NCOLS - 1);
      cy = $urandom_range(0, NPIX / NCOLS - 1);
      rad = $urandom_range(0, 2);
      idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      use_fs = need_fs || ($urandom_range(0, 3) != 0);
      broken = ($urandom_range(0, 7) == 0);
      n = broken ? $urandom_range(1, NPIX - 1) : NPIX;
      for (int i = 0; i < n; i++)
        send_pixel(frame_pixel(kind, i, cx, cy, rad), use_fs && i == 0);
      need_fs = broken;
    end
    while (pix_idx != 0) send_pixel(frame_pixel(FR_COLD, pix_idx, 0, 0, 0), 1'b0);
  endtask

  task automatic test_reset_defaults();
    idle_en = 1'b1;
    send_frame(-12'sd2048, 0, '0, NPIX - 1, 12'sd2047, 1'b1);
    send_frame(THRESH_RST, 0, '0, -1, '0, 1'b1);
    send_frame(-12'sd2048, 0, '0, 0, 12'sd108, 1'b1);
    send_frame(-12'sd2048, 0, '0, 0, 12'sd109, 1'b1);
  endtask

  task automatic test_register_extremes();
    set_config(-12'sd2048, 16'd0);
    send_frame(12'sd2047, 0, '0, -1, '0, 1'b1);
    send_frame(-12'sd2048, 0, '0, -1, '0, 1'b1);
    set_config(12'sd2047, 16'hFFFF);
    send_frame(12'sd2047, 0, '0, -1, '0, 1'b1);
    set_config(-12'sd2048, 16'hFFFF);
    send_frame(12'sd2047, 0, '0, -1, '0, 1'b1);
    // weight lands exactly on the minimum, then one above it
    send_frame(-12'sd2048, 16, 12'sd2047, 16, -12'sd2033, 1'b1);
    send_frame(-12'sd2048, 16, 12'sd2047, 16, -12'sd2032, 1'b1);
  endtask

  task automatic test_frame_restart();
    set_config(THRESH_RST, MIN_WEIGHT_RST);
    for (int i = 0; i < 20; i++) send_pixel(12'sd2047, i == 0);
    send_frame(12'sd0, 0, '0, 9, 12'sd900, 1'b1);
    send_frame(12'sd0, 0, '0, 43, 12'sd500, 1'b0);
    for (int i = 0; i < 30; i++) send_pixel(12'sd1500, 1'b0);
    send_frame(12'sd0, 0, '0, 0, 12'sd400, 1'b1);
    send_pixel(12'sd0, 1'b0);
    for (int i = 1; i < NPIX; i++) send_pixel((i == 7) ? 12'sd400 : 12'sd0, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    idle_en = 1'b0;
    hold_left = 300;
    for (int f = 0; f < 4; f++)
      for (int i = 0; i < NPIX; i++)
        send_pixel(frame_pixel(FR_BLOB, i, f, 7 - f, 1), i == 0);
  endtask

  task automatic test_random_sweep();
    temp_t thr;
    min_weight_t minw;
    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(0, 3))
        0: thr = temp_t'($urandom_range(0, 4095));
        1: thr = clamp_temp(int'($urandom_range(0, 400)) - 100);
        2: thr = -12'sd2048;
        default: thr = THRESH_RST;
      endcase
      case ($urandom_range(0, 3))
        0: minw = '0;
        1: minw = '1;
        default: minw = min_weight_t'($urandom_range(0, 3000));
      endcase
      set_config(thr, minw);
      run_frames(2, ph != 3);
    end
    idle_en = 1'b0;
  endtask

  initial begin : result_ready_drive
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        gap = $urandom_range(1, 3);
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : centroid_check
    centroid_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_centroids.size() == 0) begin
        $error("result beat with no frame pending: x %0d y %0d det %0b",
               out_ch.cent_x, out_ch.cent_y, out_ch.hot_found);
        mismatch_cnt++;
      end else begin
        want = pending_centroids.pop_front();
        if (out_ch.cent_x !== want.x) begin
          $error("cent_x expected %0d got %0d", want.x, out_ch.cent_x);
          mismatch_cnt++;
        end
        if (out_ch.cent_y !== want.y) begin
          $error("cent_y expected %0d got %0d", want.y, out_ch.cent_y);
          mismatch_cnt++;
        end
        if (out_ch.hot_found !== want.det) begin
          $error("hot_found expected %0b got %0b", want.det, out_ch.hot_found);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("thermal_grid_centroid_core verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pixel_temp = '0;
    in_ch.frame_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_HEAT_THRESHOLD;
    cfg_ch.data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_frame_restart();
    test_backpressure();
    test_random_sweep();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("thermal_grid_centroid_core verification clean");
    end else begin
      $display("thermal_grid_centroid_core verification failed");
    end
    $finish;
  end

endmodule
